@@ rtl/core/swra_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package swra_pkg;

  // Default number of stack entries.
  localparam int DEPTH_DEF = 1024;

  // Fixed field widths of the stream words.
  localparam int VAL_W     = 32;
  localparam int AVG_W     = 40;
  localparam int CNT_OUT_W = 11;
  localparam int FRAC_W    = 8;
  localparam int CODE_W    = 2;

  // Operation codes carried on the input tuser. The unused code acts as a query.
  localparam logic [CODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [CODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [CODE_W-1:0] MODE_QUERY = 2'd2;

  // Status codes carried on the output tuser.
  localparam logic [CODE_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [CODE_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [CODE_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PREP,
    S_DIV,
    S_DONE
  } swra_state_t;

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/swra_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swra_store #(
  parameter int DEPTH  = swra_pkg::DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [ADDR_W-1:0]          waddr,
  input  wire logic [swra_pkg::VAL_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [ADDR_W-1:0]          raddr,
  output logic      [swra_pkg::VAL_W-1:0] rdata
);
  import swra_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data is valid in the cycle after re.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/core/swra_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swra_div #(
  parameter int DVD_W = 50,
  parameter int DSR_W = 11
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DVD_W-1:0]    dividend,
  input  wire logic [DSR_W-1:0]    divisor,
  output logic      [DVD_W-1:0]    quotient,
  output swra_pkg::div_sts_t       sts
);
  import swra_pkg::*;

  localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DSR_W-1:0]  dsr_r;
  logic [DSR_W-1:0]  rem_r;

  logic [DSR_W:0]    trial;
  logic [DSR_W:0]    diff;
  logic              fits;
  logic [DSR_W-1:0]  rem_nxt;

  // One restoring step: bring down the next dividend bit and try the subtract.
  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    diff    = trial - {1'b0, dsr_r};
    fits    = (trial >= {1'b0, dsr_r});
    rem_nxt = fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

@@ rtl/core/stack_with_running_average_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | tdata (lowest bit up)                         | tuser
// --------+-----------+-----------------------------------------------+--------------
// in_     | slave     | push_value[31:0]                              | mode[1:0]
// out_    | master    | item_value[31:0], average_fixed[39:0],        | status[1:0]
//         |           | entry_count[10:0], zero padding[4:0]          |
//
// Each word passes through the accept, read-top, prepare, divide and hand-over states in turn;
// the divide state lasts until the restoring divider, which yields one quotient bit a cycle, is done.
// A pop or query on an empty stack, and a pop that takes the last entry, skip the divider.
// in_tready is high only while the sequencer is idle; a finished result waits in the
// output register, so a new word may be taken while out_tvalid is still pending.
// Reset is synchronous and active low; it empties the stack and clears the running sum.
// The entry memory needs no clearing, because only entries below the fill level are used.

module stack_with_running_average_top #(
  parameter int DEPTH = swra_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // push_value[31:0]
  input  wire logic [1:0]  in_tuser,   // mode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // item_value[31:0], average_fixed[71:32],
                                       // entry_count[82:72], zero[87:83]
  output logic [1:0]       out_tuser   // status[1:0]
);
  import swra_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = VAL_W + $clog2(DEPTH);
  localparam int DVD_W  = SUM_W + FRAC_W;

  swra_state_t state_r, state_nxt;

  // Stack state.
  logic [CNT_W-1:0]        fill_r;
  logic signed [SUM_W-1:0] total_r;

  // Per-word working registers.
  logic [VAL_W-1:0]  item_r;
  logic [CODE_W-1:0] status_r;
  logic              use_rd_r;
  logic              pop_r;
  logic              neg_r;
  logic              avg_zero_r;

  // Output register.
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_item_r;
  logic [AVG_W-1:0]  out_avg_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic [CODE_W-1:0] out_status_r;

  // Memory and divider hookup.
  logic              mem_we;
  logic              mem_re;
  logic [VAL_W-1:0]  mem_rdata;
  logic [CNT_W-1:0]  fill_dec;
  logic              div_start;
  logic [SUM_W-1:0]  total_mag;
  logic [DVD_W-1:0]  div_dividend;
  logic [DVD_W-1:0]  div_quotient;
  logic [DVD_W-1:0]  avg_signed;
  div_sts_t          div_sts;

  logic              in_acc;
  logic              is_full;
  logic              out_free;
  logic [CNT_W+CNT_OUT_W-1:0] fill_ext;

  assign in_acc   = in_tvalid && in_tready;
  assign is_full  = (fill_r >= CNT_W'(DEPTH));
  assign fill_dec = fill_r - 1'b1;
  assign out_free = !out_valid_r || out_tready;
  assign fill_ext = {{CNT_OUT_W{1'b0}}, fill_r};

  // Magnitude of the running sum with the fraction bits appended for the divider.
  assign total_mag    = total_r[SUM_W-1] ? SUM_W'(~total_r + 1'b1) : SUM_W'(total_r);
  assign div_dividend = {total_mag, {FRAC_W{1'b0}}};

  // Truncation toward zero: divide magnitudes, then restore the sign.
  assign avg_signed = neg_r ? (~div_quotient + 1'b1) : div_quotient;

  swra_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill_r[ADDR_W-1:0]),
    .wdata (in_tdata),
    .re    (mem_re),
    .raddr (fill_dec[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  swra_div #(
    .DVD_W (DVD_W),
    .DSR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (fill_r),
    .quotient (div_quotient),
    .sts      (div_sts)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_PREP;
      S_PREP: begin
        if (fill_r != '0) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        mem_we    = in_acc && (in_tuser == MODE_PUSH) && !is_full;
        mem_re    = in_acc;
      end
      S_PREP:  div_start = (fill_r != '0);
      S_READ, S_DIV, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Stack state: a push updates at acceptance, a pop once the top has been read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      total_r <= '0;
    end else if (state_r == S_IDLE && in_acc && in_tuser == MODE_PUSH && !is_full) begin
      fill_r  <= fill_r + 1'b1;
      total_r <= total_r + {{(SUM_W-VAL_W){in_tdata[VAL_W-1]}}, in_tdata};
    end else if (state_r == S_READ && pop_r) begin
      fill_r  <= fill_dec;
      total_r <= total_r - {{(SUM_W-VAL_W){mem_rdata[VAL_W-1]}}, mem_rdata};
    end
  end

  // Per-word bookkeeping.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      pop_r <= 1'b0;
      if (in_tuser == MODE_PUSH) begin
        if (is_full) begin
          status_r <= STATUS_FULL;
          use_rd_r <= 1'b1;
        end else begin
          status_r <= STATUS_OK;
          use_rd_r <= 1'b0;
          item_r   <= in_tdata;
        end
      end else if (fill_r == '0) begin
        status_r <= STATUS_EMPTY;
        use_rd_r <= 1'b0;
        item_r   <= '0;
      end else begin
        status_r <= STATUS_OK;
        use_rd_r <= 1'b1;
        pop_r    <= (in_tuser == MODE_POP);
      end
    end
    if (state_r == S_READ && use_rd_r) begin
      item_r <= mem_rdata;
    end
    if (state_r == S_PREP) begin
      neg_r      <= total_r[SUM_W-1];
      avg_zero_r <= (fill_r == '0);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_item_r   <= item_r;
      out_avg_r    <= avg_zero_r ? '0 : avg_signed[AVG_W-1:0];
      out_cnt_r    <= fill_ext[CNT_OUT_W-1:0];
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_cnt_r, out_avg_r, out_item_r};
  assign out_tuser  = out_status_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill level exceeds the stack depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == MODE_PUSH && !is_full) |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("accepted push did not grow the stack");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_EMPTY) |->
      (out_item_r == '0 && out_avg_r == '0 && out_cnt_r == '0))
    else $error("empty status with non-zero result fields");

  a_div_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

endmodule

`default_nettype wire
